/* hdl/rffv_pkg.sv */
// ----------------------------------------------------------------------------
// rffv_pkg
// Shared constants, register indexes and types of the radial force field
// velocity update unit.
// ----------------------------------------------------------------------------
package rffv_pkg;

    // pipeline geometry
    localparam int AXES        = 3;
    localparam int SQRT_STEPS  = 32;   // one root bit per stage
    localparam int FDIV_STEPS  = 32;   // falloff quotient bits
    localparam int QDIV_STEPS  = 31;   // per-axis quotient bits
    localparam int LANE_LAT    = QDIV_STEPS + 2;
    localparam int SQRT_BASE   = 3;
    localparam int DEC_IDX     = SQRT_BASE + SQRT_STEPS;
    localparam int FDIV_BASE   = DEC_IDX + 1;
    localparam int F2_IDX      = FDIV_BASE + FDIV_STEPS;
    localparam int M_IDX       = F2_IDX + 1;
    localparam int PRE_STAGES  = M_IDX + 1;

    // distances at or below this many LSB count as the centre itself
    localparam logic [31:0] EPS_LSB = 32'd6;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_STRENGTH = 3'd3,
        CFG_RADIUS   = 3'd4
    } t_cfg_idx;

    // one axis worth of work handed to a lane
    typedef struct packed {
        logic        aff;
        logic        neg;
        logic [30:0] m;
        logic [30:0] ad;
        logic [30:0] dlen;
        logic [31:0] vel;
    } t_lane_req;

endpackage

/* hdl/rffv_in_if.sv */
// ----------------------------------------------------------------------------
// rffv_in_if
// Particle word channel: position and velocity with valid / ready.
// ----------------------------------------------------------------------------
interface rffv_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    output ready);
endinterface

/* hdl/rffv_out_if.sv */
// ----------------------------------------------------------------------------
// rffv_out_if
// Result word channel: updated velocity and affected flag with valid / ready.
// ----------------------------------------------------------------------------
interface rffv_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic              affected;

    modport source (output valid, new_vel_x, new_vel_y, new_vel_z, affected,
                    input ready);
    modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, affected,
                    output ready);
endinterface

/* hdl/radial_force_field_velocity_update_unit.sv */
// ----------------------------------------------------------------------------
// radial_force_field_velocity_update_unit
// Point attractor with quadratic falloff: adds strength * falloff^2 along the
// unit vector to the field centre to one particle velocity per word.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_item    in   valid/ready   pos_x/y/z, vel_x/y/z (signed Q16.16)
//  o_result  out  valid/ready   new_vel_x/y/z, affected
//  i_cfg_*   in   write enable  index 0..4, 32-bit data
//
//  One word in per cycle while the pipe advances; the depth is set by the
//  32-stage square root, the 32-stage falloff divider and the
//  31-stage per-axis dividers.
//  Synchronous active-low reset clears the valid bits and configuration.
//  The whole pipe advances when the output register is empty or taken; a
//  stall freezes every stage.
// ----------------------------------------------------------------------------
module radial_force_field_velocity_update_unit
    import rffv_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rffv_in_if.sink      i_item,
    rffv_out_if.source   o_result,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

    typedef struct packed {
        logic                  v;
        logic                  hit;
        logic [AXES-1:0]       neg;
        logic [AXES-1:0][30:0] ad;
        logic [AXES-1:0][31:0] vel;
        logic [30:0]           dlen;
    } t_side;

    // configuration registers
    logic [31:0] r_ctr [AXES];
    logic [31:0] r_strength;
    logic [30:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXES; k++) begin
                r_ctr[k] <= '0;
            end
            r_strength <= '0;
            r_radius   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_ctr[0]   <= i_cfg_data;
                CFG_CENTER_Y: r_ctr[1]   <= i_cfg_data;
                CFG_CENTER_Z: r_ctr[2]   <= i_cfg_data;
                CFG_STRENGTH: r_strength <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic r_lv [LANE_LAT];
    logic r_la [LANE_LAT];

    assign adv          = !r_lv[LANE_LAT-1] || o_result.ready;
    assign i_item.ready = adv;

    // sideband line
    t_side r_sd [PRE_STAGES];
    t_side n_sd [PRE_STAGES];

    // front: difference vectors and the per-axis box test
    logic [31:0]        c_pos [AXES];
    logic [31:0]        c_vel [AXES];
    logic signed [32:0] c_d   [AXES];
    logic [32:0]        c_ad  [AXES];
    logic               c_near;

    assign c_pos[0] = i_item.pos_x;
    assign c_pos[1] = i_item.pos_y;
    assign c_pos[2] = i_item.pos_z;
    assign c_vel[0] = i_item.vel_x;
    assign c_vel[1] = i_item.vel_y;
    assign c_vel[2] = i_item.vel_z;

    always_comb begin
        c_near = 1'b1;
        n_sd[0] = '0;
        for (int k = 0; k < AXES; k++) begin
            c_d[k]  = $signed({r_ctr[k][31], r_ctr[k]}) - $signed({c_pos[k][31], c_pos[k]});
            c_ad[k] = c_d[k][32] ? 33'(-c_d[k]) : 33'(c_d[k]);
            if (c_ad[k] > 33'(r_radius)) begin
                c_near = 1'b0;
            end
            n_sd[0].neg[k] = c_d[k][32];
            n_sd[0].ad[k]  = c_ad[k][30:0];
            n_sd[0].vel[k] = c_vel[k];
        end
        n_sd[0].v   = i_item.valid;
        n_sd[0].hit = c_near;
    end

    // squares, then their sum
    logic [61:0] r_sq [AXES];
    logic [63:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < AXES; k++) begin
                r_sq[k] <= r_sd[0].hit ? 62'(r_sd[0].ad[k]) * 62'(r_sd[0].ad[k]) : '0;
            end
            r_sum <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
        end
    end

    // square root, one result bit per stage
    logic [63:0] r_sx [SQRT_STEPS];
    logic [63:0] r_sr [SQRT_STEPS];
    logic [63:0] sx_in [SQRT_STEPS];
    logic [63:0] sr_in [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] BITV = 64'(1) << (2 * (SQRT_STEPS - 1 - j));
        if (j == 0) begin : g_first
            assign sx_in[j] = r_sum;
            assign sr_in[j] = '0;
        end else begin : g_next
            assign sx_in[j] = r_sx[j-1];
            assign sr_in[j] = r_sr[j-1];
        end

        logic [63:0] c_trial;
        assign c_trial = sr_in[j] + BITV;

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (sx_in[j] >= c_trial) begin
                    r_sx[j] <= sx_in[j] - c_trial;
                    r_sr[j] <= (sr_in[j] >> 1) + BITV;
                end else begin
                    r_sx[j] <= sx_in[j];
                    r_sr[j] <= sr_in[j] >> 1;
                end
            end
        end
    end

    // decide: range test on the distance, seed the falloff divider
    logic [31:0] c_dist;
    logic        c_aff;
    logic [30:0] r_rem0;

    assign c_dist = r_sr[SQRT_STEPS-1][31:0];
    assign c_aff  = r_sd[DEC_IDX-1].hit && (c_dist > EPS_LSB)
                    && (c_dist <= {1'b0, r_radius});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem0 <= c_aff ? 31'(r_radius - c_dist[30:0]) : '0;
        end
    end

    // falloff divider: (radius - dist) * 2^32 / radius
    logic [30:0] r_frem [FDIV_STEPS];
    logic [31:0] r_fq   [FDIV_STEPS];
    logic [30:0] frem_in [FDIV_STEPS];
    logic [31:0] fq_in   [FDIV_STEPS];

    for (genvar j = 0; j < FDIV_STEPS; j++) begin : g_fdiv
        if (j == 0) begin : g_first
            assign frem_in[j] = r_rem0;
            assign fq_in[j]   = '0;
        end else begin : g_next
            assign frem_in[j] = r_frem[j-1];
            assign fq_in[j]   = r_fq[j-1];
        end

        logic [31:0] c_t;
        logic        c_ge;
        assign c_t  = {frem_in[j], 1'b0};
        assign c_ge = c_t >= {1'b0, r_radius};

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_frem[j] <= c_ge ? 31'(c_t - {1'b0, r_radius}) : c_t[30:0];
                r_fq[j]   <= {fq_in[j][30:0], c_ge};
            end
        end
    end

    // falloff squared, then scaled by |strength|
    logic [31:0] r_f2;
    logic [30:0] r_m;
    logic [31:0] c_sabs;

    assign c_sabs = r_strength[31] ? 32'(-r_strength) : r_strength;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f2 <= 32'((64'(r_fq[FDIV_STEPS-1]) * 64'(r_fq[FDIV_STEPS-1])) >> 32);
            r_m  <= 31'((64'(c_sabs) * 64'(r_f2)) >> 32);
        end
    end

    // sideband next values
    for (genvar s = 1; s < PRE_STAGES; s++) begin : g_side
        if (s == DEC_IDX) begin : g_dec
            always_comb begin
                n_sd[s]      = r_sd[s-1];
                n_sd[s].hit  = c_aff;
                n_sd[s].dlen = c_dist[30:0];
            end
        end else begin : g_pass
            assign n_sd[s] = r_sd[s-1];
        end
    end

    // advance sideband; reset clears only the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PRE_STAGES; s++) begin
                r_sd[s].v <= 1'b0;
            end
        end else if (adv) begin
            for (int s = 0; s < PRE_STAGES; s++) begin
                r_sd[s] <= n_sd[s];
            end
        end
    end

    // per-axis lanes
    t_lane_req   c_req [AXES];
    logic [31:0] c_nv  [AXES];

    for (genvar k = 0; k < AXES; k++) begin : g_lane
        assign c_req[k] = '{
            aff:  r_sd[M_IDX].hit,
            neg:  r_strength[31] ^ r_sd[M_IDX].neg[k],
            m:    r_m,
            ad:   r_sd[M_IDX].ad[k],
            dlen: r_sd[M_IDX].dlen,
            vel:  r_sd[M_IDX].vel[k]
        };

        rffv_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (adv),
            .i_req     (c_req[k]),
            .o_new_vel (c_nv[k])
        );
    end

    // valid and affected alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LANE_LAT; s++) begin
                r_lv[s] <= 1'b0;
            end
        end else if (adv) begin
            r_lv[0] <= r_sd[M_IDX].v;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_lv[s] <= r_lv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_la[0] <= r_sd[M_IDX].hit;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_la[s] <= r_la[s-1];
            end
        end
    end

    assign o_result.valid     = r_lv[LANE_LAT-1];
    assign o_result.affected  = r_la[LANE_LAT-1];
    assign o_result.new_vel_x = c_nv[0];
    assign o_result.new_vel_y = c_nv[1];
    assign o_result.new_vel_z = c_nv[2];

    // an affected word always has its distance inside (eps, radius]
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd[DEC_IDX].v && r_sd[DEC_IDX].hit |->
            ({1'b0, r_sd[DEC_IDX].dlen} > EPS_LSB)
            && (r_sd[DEC_IDX].dlen <= r_radius))
        else $error("affected word with distance out of range");

    // falloff remainder stays below the radius for affected words
    a_fdiv_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd[F2_IDX-1].v && r_sd[F2_IDX-1].hit |->
            r_frem[FDIV_STEPS-1] < r_radius)
        else $error("falloff divider remainder not below radius");

    // a stalled pipe keeps the affected flag of the held word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.ready |=> $stable(r_la[LANE_LAT-1]))
        else $error("held result changed its flag");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");

endmodule

/* hdl/rffv_lane.sv */
// ----------------------------------------------------------------------------
// rffv_lane
// One axis: m * |d| / dist through a pipelined restoring divider, then the
// signed, saturated velocity sum.
// ----------------------------------------------------------------------------
module rffv_lane
    import rffv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_lane_req   i_req,
    output logic [31:0] o_new_vel
);

    localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

    // product stage
    logic [61:0] r_p;
    logic [30:0] r_pd;
    logic        r_pn;
    logic        r_pa;
    logic [31:0] r_pv;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= 62'(i_req.m) * 62'(i_req.ad);
            r_pd <= i_req.dlen;
            r_pn <= i_req.neg;
            r_pa <= i_req.aff;
            r_pv <= i_req.vel;
        end
    end

    // divider stages, one quotient bit each
    logic [30:0] r_rem [QDIV_STEPS];
    logic [30:0] r_q   [QDIV_STEPS];
    logic [30:0] r_lo  [QDIV_STEPS];
    logic [30:0] r_dd  [QDIV_STEPS];
    logic        r_nn  [QDIV_STEPS];
    logic        r_aa  [QDIV_STEPS];
    logic [31:0] r_vv  [QDIV_STEPS];

    logic [30:0] rem_in [QDIV_STEPS];
    logic [30:0] q_in   [QDIV_STEPS];
    logic [30:0] lo_in  [QDIV_STEPS];
    logic [30:0] dd_in  [QDIV_STEPS];
    logic        nn_in  [QDIV_STEPS];
    logic        aa_in  [QDIV_STEPS];
    logic [31:0] vv_in  [QDIV_STEPS];

    for (genvar j = 0; j < QDIV_STEPS; j++) begin : g_div
        if (j == 0) begin : g_first
            assign rem_in[j] = r_p[61:31];
            assign q_in[j]   = '0;
            assign lo_in[j]  = r_p[30:0];
            assign dd_in[j]  = r_pd;
            assign nn_in[j]  = r_pn;
            assign aa_in[j]  = r_pa;
            assign vv_in[j]  = r_pv;
        end else begin : g_next
            assign rem_in[j] = r_rem[j-1];
            assign q_in[j]   = r_q[j-1];
            assign lo_in[j]  = r_lo[j-1];
            assign dd_in[j]  = r_dd[j-1];
            assign nn_in[j]  = r_nn[j-1];
            assign aa_in[j]  = r_aa[j-1];
            assign vv_in[j]  = r_vv[j-1];
        end

        logic [31:0] c_t;
        logic        c_ge;
        assign c_t  = {rem_in[j], lo_in[j][30]};
        assign c_ge = c_t >= {1'b0, dd_in[j]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= c_ge ? 31'(c_t - {1'b0, dd_in[j]}) : c_t[30:0];
                r_q[j]   <= {q_in[j][29:0], c_ge};
                r_lo[j]  <= {lo_in[j][29:0], 1'b0};
                r_dd[j]  <= dd_in[j];
                r_nn[j]  <= nn_in[j];
                r_aa[j]  <= aa_in[j];
                r_vv[j]  <= vv_in[j];
            end
        end
    end

    // saturating sum
    logic signed [33:0] c_add;
    logic signed [33:0] c_sum;
    logic [31:0]        r_out;

    always_comb begin
        c_add = $signed({3'b000, r_q[QDIV_STEPS-1]});
        if (r_nn[QDIV_STEPS-1]) begin
            c_add = -c_add;
        end
        if (!r_aa[QDIV_STEPS-1]) begin
            c_add = '0;
        end
        c_sum = $signed({{2{r_vv[QDIV_STEPS-1][31]}}, r_vv[QDIV_STEPS-1]}) + c_add;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (c_sum > SAT_MAX) begin
                r_out <= 32'h7FFF_FFFF;
            end else if (c_sum < SAT_MIN) begin
                r_out <= 32'h8000_0000;
            end else begin
                r_out <= c_sum[31:0];
            end
        end
    end

    assign o_new_vel = r_out;

endmodule
